// File: hw/rtl/pip_pkg.sv
package pip_pkg;

  localparam int COORD_BITS = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // request modes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // response status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    coord_t     coord_x;
    coord_t     coord_y;
  } in_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } out_t;

  // control from the sequencer to the edge unit
  typedef struct packed {
    logic sel_second;
    logic cap_first;
    logic cap_second;
  } edge_ctl_t;

endpackage

// File: hw/rtl/pip_vstore.sv
module pip_vstore #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pip_pkg::coord_t wx,
  input  pip_pkg::coord_t wy,
  input  logic [AW-1:0]   raddr,
  output pip_pkg::coord_t rx,
  output pip_pkg::coord_t ry
);
  import pip_pkg::*;

  coord_t mem_x [DEPTH];
  coord_t mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

endmodule

// File: hw/rtl/pip_edge_unit.sv
module pip_edge_unit (
  input  logic               clk,
  input  pip_pkg::edge_ctl_t ctl,
  input  pip_pkg::coord_t    ex0,
  input  pip_pkg::coord_t    ey0,
  input  pip_pkg::coord_t    ex1,
  input  pip_pkg::coord_t    ey1,
  input  pip_pkg::coord_t    qx,
  input  pip_pkg::coord_t    qy,
  output logic               qual,
  output logic               less
);
  import pip_pkg::*;

  localparam int DW = COORD_BITS + 2;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dy, dx, a, dxq, a_adj, dy_abs, opa, opb;
  logic signed [PW-1:0] product, p1, p2;
  logic                 straddle, x_ok;

  assign dy  = DW'(ey1) - DW'(ey0);
  assign dx  = DW'(ex1) - DW'(ex0);
  assign a   = DW'(qy) - DW'(ey0);
  assign dxq = DW'(qx) - DW'(ex0);

  // flip the sign so the y span is positive
  assign a_adj  = dy[DW-1] ? -a  : a;
  assign dy_abs = dy[DW-1] ? -dy : dy;

  assign straddle = (ey0 < qy && ey1 >= qy) || (ey1 < qy && ey0 >= qy);
  assign x_ok     = (ex0 <= qx) || (ex1 <= qx);

  // one shared multiplier, two operand pairs
  assign opa     = ctl.sel_second ? dxq    : a_adj;
  assign opb     = ctl.sel_second ? dy_abs : dx;
  assign product = PW'(opa) * PW'(opb);

  always_ff @(posedge clk) begin
    if (ctl.cap_first) begin
      p1   <= product;
      qual <= straddle && x_ok;
    end
    if (ctl.cap_second) begin
      p2 <= product;
    end
  end

  assign less = p1 < p2;

endmodule

// File: hw/rtl/point_in_polygon_test.sv
// Crossing-number point-in-polygon test.
// Request channel (req_valid/req_ready/req): each transaction carries a mode,
// an x and a y. Start clears the polygon and stores the vertex; append adds
// a vertex (dropped and flagged once MAX_VERTICES are held); query tests the
// point against the closed polygon. Mode three is taken and ignored.
// Response channel (rsp_valid/rsp_ready/rsp): one transaction per query,
// with the crossing parity and a status (ok, empty, vertices dropped).
// Start and append leave the sequencer in IDLE, so req_ready stays high.
// A query over N stored vertices makes one read-and-load pass (RD, LOAD)
// per vertex from the vertex RAM, and each edge then takes MUL_A, MUL_B and
// CMP on the shared multiplier (two products and a compare). An empty polygon
// goes from IDLE straight to FINISH. The multiplier sets the per-edge cost.
// req_ready is low for the whole query. A finished response sits in the
// output register; if the previous one is still stalled, the sequencer
// holds in FINISH until rsp_ready frees the register.
// Reset (synchronous, rst high) empties the polygon, clears the overflow
// flag and drops any pending response; the vertex RAM is not cleared.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pip_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pip_pkg::out_t rsp
);
  import pip_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    IDLE, RD, LOAD, MUL_A, MUL_B, CMP, FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] total;        // stored vertex count
  logic          ovf;          // vertex dropped since last start
  logic [AW-1:0] idx;          // vertex being fetched
  coord_t        qx, qy;       // query point
  coord_t        ex0, ey0, ex1, ey1;  // current edge
  coord_t        firstx, firsty;
  coord_t        prevx, prevy;
  logic          close_next;   // closing edge follows this one
  logic          last_edge;    // this is the final edge
  logic          flag;         // crossing parity
  logic [1:0]    res_status;

  logic          req_fire, we, room;
  logic          rsp_load;     // output register takes a new response
  logic [AW-1:0] waddr, last_idx;
  coord_t        rx, ry;
  edge_ctl_t     ectl;
  logic          qual, less;

  assign req_ready = (state == IDLE);
  assign req_fire  = req_valid && req_ready;
  assign room      = total < CW'(MAX_VERTICES);
  assign we        = req_fire && ((req.mode == MODE_START) ||
                                  (req.mode == MODE_APPEND && room));
  assign waddr     = (req.mode == MODE_START) ? '0 : total[AW-1:0];
  assign last_idx  = AW'(total - CW'(1));
  assign rsp_load  = (state == FINISH) && (!rsp_valid || rsp_ready);

  always_comb begin
    ectl = '0;
    case (state)
      MUL_A: begin
        ectl.cap_first = 1'b1;
      end
      MUL_B: begin
        ectl.sel_second = 1'b1;
        ectl.cap_second = 1'b1;
      end
      default: ectl = '0;
    endcase
  end

  pip_vstore #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_vstore (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wx    (req.coord_x),
    .wy    (req.coord_y),
    .raddr (idx),
    .rx    (rx),
    .ry    (ry)
  );

  pip_edge_unit u_edge (
    .clk  (clk),
    .ctl  (ectl),
    .ex0  (ex0),
    .ey0  (ey0),
    .ex1  (ex1),
    .ey1  (ey1),
    .qx   (qx),
    .qy   (qy),
    .qual (qual),
    .less (less)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      total      <= '0;
      ovf        <= 1'b0;
      idx        <= '0;
      close_next <= 1'b0;
      last_edge  <= 1'b0;
      flag       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // a new response replaces one that leaves in the same cycle
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_fire) begin
            case (req.mode)
              MODE_START: begin
                total <= CW'(1);
                ovf   <= 1'b0;
              end
              MODE_APPEND: begin
                if (room) begin
                  total <= total + CW'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              MODE_QUERY: begin
                qx         <= req.coord_x;
                qy         <= req.coord_y;
                idx        <= '0;
                flag       <= 1'b0;
                close_next <= 1'b0;
                last_edge  <= 1'b0;
                if (total == '0) begin
                  res_status <= STATUS_EMPTY;
                  state      <= FINISH;
                end else begin
                  res_status <= ovf ? STATUS_DROPPED : STATUS_OK;
                  state      <= RD;
                end
              end
              default: ;
            endcase
          end
        end
        RD: begin
          state <= LOAD;
        end
        LOAD: begin
          prevx <= rx;
          prevy <= ry;
          if (idx == '0) begin
            firstx <= rx;
            firsty <= ry;
            if (idx == last_idx) begin
              // lone vertex: edge back onto itself
              ex0       <= rx;
              ey0       <= ry;
              ex1       <= rx;
              ey1       <= ry;
              last_edge <= 1'b1;
              state     <= MUL_A;
            end else begin
              idx   <= idx + AW'(1);
              state <= RD;
            end
          end else begin
            ex0        <= prevx;
            ey0        <= prevy;
            ex1        <= rx;
            ey1        <= ry;
            close_next <= (idx == last_idx);
            state      <= MUL_A;
          end
        end
        MUL_A: begin
          state <= MUL_B;
        end
        MUL_B: begin
          state <= CMP;
        end
        CMP: begin
          if (qual && less) begin
            flag <= ~flag;
          end
          if (close_next) begin
            // last vertex back to the first
            ex0        <= ex1;
            ey0        <= ey1;
            ex1        <= firstx;
            ey1        <= firsty;
            close_next <= 1'b0;
            last_edge  <= 1'b1;
            state      <= MUL_A;
          end else if (last_edge) begin
            state <= FINISH;
          end else begin
            idx   <= idx + AW'(1);
            state <= RD;
          end
        end
        FINISH: begin
          if (rsp_load) begin
            rsp.inside_res <= (res_status == STATUS_EMPTY) ? 1'b0 : flag;
            rsp.status     <= res_status;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/pip_checker.sv
module pip_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input pip_pkg::in_t  req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input pip_pkg::out_t rsp
);
  import pip_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed or dropped");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.mode == MODE_QUERY |=> !req_ready)
    else $error("request taken during a query");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == STATUS_OK || rsp.status == STATUS_EMPTY ||
                  rsp.status == STATUS_DROPPED)
    else $error("bad response status");

  a_empty_outside: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_EMPTY |-> !rsp.inside_res)
    else $error("empty polygon reported inside");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

// File: verif/point_in_polygon_test_tb.sv
module point_in_polygon_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  // Capacity of the vertex store in the instance under test.
  localparam int VERTEX_SLOTS = 64;
  // The package names modes 0..2; the fourth encoding is taken and ignored.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Longest legal silence on both channels: a full 64-vertex query plus the
  // long receiver hold-off plus random stalls, taken many times.
  localparam int WATCHDOG_LIMIT = 20000;
  // Tail after the last expected response: one full-size query.
  localparam int DRAIN_CYCLES   = 400;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASE_ITEMS    = 500;

  // Scoreboard: keeps its own copy of the polygon, predicts each query
  // response when the request transaction is accepted, and checks the
  // responses in order.
  class pip_scoreboard;
    coord_t      vert_x [VERTEX_SLOTS];
    coord_t      vert_y [VERTEX_SLOTS];
    int unsigned vert_count;
    bit          dropped;
    out_t        verdict_q [$];
    int unsigned failures;

    function new();
      vert_count = 0;
      dropped    = 1'b0;
      failures   = 0;
    endfunction

    // Crossing parity over the closed polygon, exact in 64-bit products.
    function bit crossing_parity(coord_t px, coord_t py);
      bit     parity;
      int     i;
      int     j;
      longint ax, ay, bx, by, qx, qy, dy, num;
      parity = 1'b0;
      qx = px;
      qy = py;
      for (i = 0; i < vert_count; i++) begin
        j  = (i + 1 < vert_count) ? i + 1 : 0;
        ax = vert_x[i];
        ay = vert_y[i];
        bx = vert_x[j];
        by = vert_y[j];
        if (((ay < qy && by >= qy) || (by < qy && ay >= qy)) && (ax <= qx || bx <= qx)) begin
          dy  = by - ay;
          num = qy - ay;
          if (dy < 0) begin
            dy  = -dy;
            num = -num;
          end
          // crossing x strictly left of the point
          if (num * (bx - ax) < (qx - ax) * dy)
            parity = ~parity;
        end
      end
      return parity;
    endfunction

    function void note_request(in_t r);
      out_t verdict;
      case (r.mode)
        MODE_START, MODE_APPEND: begin
          if (r.mode == MODE_START) begin
            vert_count = 0;
            dropped    = 1'b0;
          end
          if (vert_count < VERTEX_SLOTS) begin
            vert_x[vert_count] = r.coord_x;
            vert_y[vert_count] = r.coord_y;
            vert_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        MODE_QUERY: begin
          if (vert_count == 0) begin
            verdict.inside_res = 1'b0;
            verdict.status     = STATUS_EMPTY;
          end else begin
            verdict.inside_res = crossing_parity(r.coord_x, r.coord_y);
            verdict.status     = dropped ? STATUS_DROPPED : STATUS_OK;
          end
          verdict_q.push_back(verdict);
        end
        default: ;
      endcase
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected response inside_res=%0b status=%0d",
                 $time, got.inside_res, got.status);
        failures++;
        return;
      end
      want = verdict_q.pop_front();
      if (got.inside_res !== want.inside_res) begin
        $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                 $time, want.inside_res, got.inside_res);
        failures++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        failures++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp;

  pip_scoreboard sb;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  bit            hold_pending   = 1'b0;
  int unsigned   items_sent     = 0;
  int unsigned   quiet_cycles   = 0;

  always #4 clk = ~clk;

  point_in_polygon_test #(
    .MAX_VERTICES(VERTEX_SLOTS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Response side: random back-pressure, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering transactions
  // and the block backs up into a stalled request channel.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response monitor and watchdog. The watchdog counts cycles in which
  // neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (rsp_valid && rsp_ready)
        sb.check_response(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d responses outstanding", $time, sb.pending());
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called and returns at a falling edge. Optional idle cycles first, then
  // the transaction is held until the handshake completes.
  task automatic send_item(input logic [1:0] mode, input coord_t x, input coord_t y);
    in_t item;
    item.mode    = mode;
    item.coord_x = x;
    item.coord_y = y;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req       <= in_t'($urandom);
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    sb.note_request(item);
    if (mode != MODE_UNUSED)
      items_sent++;
    @(negedge clk);
  endtask

  // span 0 means the full coordinate range
  function automatic coord_t rand_coord(int span);
    int v;
    if (span == 0)
      return coord_t'($urandom);
    v = int'($urandom_range(2 * span)) - span;
    return coord_t'(v);
  endfunction

  // One well-formed sequence: start, appends, queries. Noise is sprinkled
  // in: ignored mode-three transactions, late appends, full-range queries.
  task automatic run_polygon(input int n_verts, input int n_queries, input int span);
    coord_t px [80];
    coord_t py [80];
    coord_t qx;
    coord_t qy;
    int     k;
    int     pick;
    int     kept;
    kept = (n_verts < 80) ? n_verts : 80;
    for (k = 0; k < kept; k++) begin
      px[k] = rand_coord(span);
      py[k] = rand_coord(span);
    end
    if ($urandom_range(9) == 0)
      send_item(MODE_UNUSED, coord_t'($urandom), coord_t'($urandom));
    send_item(MODE_START, px[0], py[0]);
    for (k = 1; k < n_verts; k++)
      send_item(MODE_APPEND, px[k % 80], py[k % 80]);
    for (k = 0; k < n_queries; k++) begin
      pick = $urandom_range(kept - 1);
      case ($urandom_range(7))
        0: begin         // exactly on a vertex
          qx = px[pick];
          qy = py[pick];
        end
        1: begin         // on a vertex's row
          qx = rand_coord(span);
          qy = py[pick];
        end
        2: begin         // on a vertex's column
          qx = px[pick];
          qy = rand_coord(span);
        end
        3: begin
          qx = coord_t'($urandom);
          qy = coord_t'($urandom);
        end
        default: begin
          qx = rand_coord(span);
          qy = rand_coord(span);
        end
      endcase
      send_item(MODE_QUERY, qx, qy);
      if ($urandom_range(19) == 0)
        send_item(MODE_APPEND, rand_coord(span), rand_coord(span));
      if ($urandom_range(19) == 0)
        send_item(MODE_UNUSED, coord_t'($urandom), coord_t'($urandom));
    end
  endtask

  initial begin
    int phase;
    int target;
    int n_verts;
    int span;
    int roll;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // empty polygon, ignored mode, append into an empty polygon
    send_item(MODE_QUERY, 0, 0);
    send_item(MODE_UNUSED, -32768, 32767);
    send_item(MODE_QUERY, 32767, -32768);
    send_item(MODE_APPEND, -100, -100);
    send_item(MODE_APPEND, 100, -100);
    send_item(MODE_APPEND, 100, 100);
    send_item(MODE_APPEND, -100, 100);
    // square: center, on each side, outside
    send_item(MODE_QUERY, 0, 0);
    send_item(MODE_QUERY, -100, 0);
    send_item(MODE_QUERY, 100, 0);
    send_item(MODE_QUERY, 0, -100);
    send_item(MODE_QUERY, 0, 100);
    send_item(MODE_QUERY, 200, 0);
    // square spanning the whole coordinate range
    send_item(MODE_START, -32768, -32768);
    send_item(MODE_APPEND, 32767, -32768);
    send_item(MODE_APPEND, 32767, 32767);
    send_item(MODE_APPEND, -32768, 32767);
    send_item(MODE_QUERY, 0, 0);
    send_item(MODE_QUERY, 32767, 32767);
    send_item(MODE_QUERY, -32768, -32768);
    send_item(MODE_QUERY, -32768, 0);
    // single vertex polygon
    send_item(MODE_START, 5, 5);
    send_item(MODE_QUERY, 5, 5);
    send_item(MODE_QUERY, 5, 6);

    // ---- random part, four back-pressure phases ----
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_pending   = 1'b1;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        roll = $urandom_range(99);
        // mostly small polygons; a few near or past capacity
        if (phase == 0 && items_sent < 100)
          n_verts = 66;
        else if (roll < 3)
          n_verts = $urandom_range(65, 72);
        else if (roll < 8)
          n_verts = $urandom_range(40, 64);
        else
          n_verts = $urandom_range(1, 10);
        case ($urandom_range(3))
          0:       span = 8;
          1:       span = 200;
          2:       span = 16000;
          default: span = 0;
        endcase
        run_polygon(n_verts, $urandom_range(1, 6), span);
      end
    end

    req_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: point_in_polygon_test.f
hw/rtl/pip_pkg.sv
hw/rtl/pip_vstore.sv
hw/rtl/pip_edge_unit.sv
hw/rtl/point_in_polygon_test.sv
hw/rtl/pip_checker.sv
verif/point_in_polygon_test_tb.sv
